>>> sv/rrk_pkg.sv
// rrk_pkg: shared types and constants for the round-robin key ring.
// Used by rrk_cell and round_robin_key_ring; no dependencies.
`default_nettype none

package rrk_pkg;

	localparam int RRK_CAPACITY = 16;
	localparam int RRK_KEY_BITS = 32;
	localparam int CNT_MAX_W    = 9;   // holds a count up to 256 entries
	localparam int PORT_KEY_W   = 32;

	typedef enum logic [2:0] {
		OP_ADD    = 3'd0,
		OP_REMOVE = 3'd1,
		OP_ROTATE = 3'd2,
		OP_LIST   = 3'd3,
		OP_CLEAR  = 3'd4
	} op_e;

	typedef enum logic [2:0] {
		ST_ADDED   = 3'd0,
		ST_REMOVED = 3'd1,
		ST_EMPTY   = 3'd2,
		ST_NEXT    = 3'd3,
		ST_LISTED  = 3'd4,
		ST_CLEARED = 3'd5,
		ST_FULL    = 3'd6
	} status_e;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_LIST,
		S_REPORT
	} fsm_e;

	typedef enum logic [1:0] {
		CMD_HOLD,
		CMD_ROTATE,
		CMD_DROP,
		CMD_APPEND
	} cell_cmd_e;

	typedef struct packed {
		cell_cmd_e              cmd;
		logic [CNT_MAX_W-1:0]   count;
	} ring_ctl_t;

endpackage

`default_nettype wire

>>> sv/round_robin_key_ring.sv
// round_robin_key_ring: top level, the sequencer and the row of rrk_cell ring positions.
// Depends on rrk_pkg and rrk_cell.
`default_nettype none

// Ordered ring of up to CAPACITY keys (CAPACITY at most 256); position zero is the
// current turn. The ring is a row of cells that shift toward the head and wrap the
// head into the tail. Add, rotate, clear and every empty-ring or full error give one
// beat; an unknown operation gives none. Remove circulates the whole ring once, one
// position per cycle, dropping the first match at the head; a hit then gives one beat
// once the output is free, and a miss gives no beat. List circulates the ring likewise,
// giving one beat per entry, and waits while the output is stalled. One request is
// worked on at a time; a request is accepted only when the output register is empty
// or its beat leaves in the same cycle.
module round_robin_key_ring
	import rrk_pkg::*;
#(
	parameter int CAPACITY = RRK_CAPACITY,
	parameter int KEY_BITS = RRK_KEY_BITS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  req_valid,
	output logic                       req_stall,
	input  wire logic [2:0]            operation,
	input  wire logic [PORT_KEY_W-1:0] player_key,
	output logic                       rsp_valid,
	input  wire logic                  rsp_stall,
	output logic [2:0]                 status,
	output logic [PORT_KEY_W-1:0]      result_key,
	output logic                       last
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [KEY_BITS-1:0] entries [CAPACITY];

	fsm_e                state_q, state_d;
	logic [CNT_W-1:0]    count_q, count_d;
	logic [CNT_W-1:0]    steps_q, steps_d;
	logic                found_q, found_d;
	logic [KEY_BITS-1:0] key_q, key_d;

	logic                rsp_valid_q;
	status_e             status_q;
	logic [KEY_BITS-1:0] rkey_q;
	logic                last_q;

	logic                out_free;
	logic                accept;
	logic                emit;
	status_e             emit_status;
	logic [KEY_BITS-1:0] emit_key;
	logic                emit_last;
	cell_cmd_e           cmd;
	ring_ctl_t           ctl;
	logic [KEY_BITS-1:0] op_key;
	logic                ring_empty;

	assign out_free   = !rsp_valid_q || !rsp_stall;
	assign req_stall  = !(state_q == S_IDLE && out_free);
	assign accept     = req_valid && !req_stall;
	assign op_key     = KEY_BITS'(player_key);
	assign ring_empty = count_q == '0;

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		steps_d     = steps_q;
		found_d     = found_q;
		key_d       = key_q;
		cmd         = CMD_HOLD;
		emit        = 1'b0;
		emit_status = ST_EMPTY;
		emit_key    = '0;
		emit_last   = 1'b1;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (op_e'(operation))
						OP_ADD: begin
							emit     = 1'b1;
							emit_key = op_key;
							if (count_q == CNT_W'(CAPACITY)) begin
								emit_status = ST_FULL;
							end else begin
								emit_status = ST_ADDED;
								cmd         = CMD_APPEND;
								count_d     = count_q + CNT_W'(1);
							end
						end
						OP_REMOVE: begin
							if (ring_empty) begin
								emit = 1'b1;
							end else begin
								state_d = S_SCAN;
								steps_d = count_q;
								found_d = 1'b0;
								key_d   = op_key;
							end
						end
						OP_ROTATE: begin
							emit = 1'b1;
							if (!ring_empty) begin
								cmd         = CMD_ROTATE;
								emit_status = ST_NEXT;
								emit_key    = (count_q > CNT_W'(1)) ? entries[1] : entries[0];
							end
						end
						OP_LIST: begin
							if (ring_empty) begin
								emit = 1'b1;
							end else begin
								state_d = S_LIST;
								steps_d = count_q;
							end
						end
						OP_CLEAR: begin
							emit = 1'b1;
							if (!ring_empty) begin
								emit_status = ST_CLEARED;
								count_d     = '0;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_SCAN: begin
				if (!found_q && entries[0] == key_q) begin
					cmd     = CMD_DROP;
					count_d = count_q - CNT_W'(1);
					found_d = 1'b1;
				end else begin
					cmd = CMD_ROTATE;
				end
				steps_d = steps_q - CNT_W'(1);
				if (steps_q == CNT_W'(1)) begin
					state_d = found_d ? S_REPORT : S_IDLE;
				end
			end
			S_LIST: begin
				if (out_free) begin
					emit        = 1'b1;
					emit_status = ST_LISTED;
					emit_key    = entries[0];
					emit_last   = steps_q == CNT_W'(1);
					cmd         = CMD_ROTATE;
					steps_d     = steps_q - CNT_W'(1);
					if (steps_q == CNT_W'(1)) begin
						state_d = S_IDLE;
					end
				end
			end
			S_REPORT: begin
				if (out_free) begin
					emit        = 1'b1;
					emit_status = ST_REMOVED;
					emit_key    = key_q;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			steps_q     <= '0;
			found_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			steps_q <= steps_d;
			found_q <= found_d;
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		key_q <= key_d;
		if (emit) begin
			status_q <= emit_status;
			rkey_q   <= emit_key;
			last_q   <= emit_last;
		end
	end

	assign ctl.cmd   = cmd;
	assign ctl.count = CNT_MAX_W'(count_q);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		rrk_cell #(
			.INDEX   (i),
			.KEY_BITS(KEY_BITS)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.head      (entries[0]),
			.next_entry(entries[(i + 1) % CAPACITY]),
			.append_key(op_key),
			.entry_q   (entries[i])
		);
	end

	assign rsp_valid  = rsp_valid_q;
	assign status     = status_q;
	assign result_key = PORT_KEY_W'(rkey_q);
	assign last       = last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_single_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && found_q) |-> cmd != CMD_DROP)
		else $error("second drop in one remove");

	a_list_ends_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LIST && steps_q == CNT_W'(1) && out_free)
		|=> (rsp_valid_q && last_q && state_q == S_IDLE))
		else $error("listing did not end with last beat");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && operation == OP_CLEAR) |=> count_q == '0)
		else $error("clear left entries");

endmodule

`default_nettype wire

>>> sv/rrk_cell.sv
// rrk_cell: one ring position, holding a single key.
// Takes its neighbor's key, the head key or the appended key per ring command; uses rrk_pkg.
`default_nettype none

module rrk_cell
	import rrk_pkg::*;
#(
	parameter int INDEX    = 0,
	parameter int KEY_BITS = RRK_KEY_BITS
) (
	input  wire logic                clk,
	input  wire ring_ctl_t           ctl,
	input  wire logic [KEY_BITS-1:0] head,
	input  wire logic [KEY_BITS-1:0] next_entry,
	input  wire logic [KEY_BITS-1:0] append_key,
	output logic      [KEY_BITS-1:0] entry_q
);

	logic is_tail;
	logic below_tail;
	logic is_free;

	assign is_tail    = CNT_MAX_W'(INDEX + 1) == ctl.count;
	assign below_tail = CNT_MAX_W'(INDEX + 1) < ctl.count;
	assign is_free    = CNT_MAX_W'(INDEX) == ctl.count;

	always_ff @(posedge clk) begin
		case (ctl.cmd)
			CMD_ROTATE: begin
				if (is_tail) begin
					entry_q <= head;
				end else if (below_tail) begin
					entry_q <= next_entry;
				end
			end
			CMD_DROP: begin
				if (below_tail) begin
					entry_q <= next_entry;
				end
			end
			CMD_APPEND: begin
				if (is_free) begin
					entry_q <= append_key;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

>>> sim/round_robin_key_ring_checker.sv
// round_robin_key_ring_checker: watches the request and response channels of the key ring,
// keeps its own copy of the turn order and compares every response beat with the prediction.
// Depends on rrk_pkg.
`default_nettype none

module round_robin_key_ring_checker
	import rrk_pkg::*;
#(
	parameter int CAPACITY = RRK_CAPACITY,
	parameter int KEY_BITS = RRK_KEY_BITS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  req_valid,
	input  wire logic                  req_stall,
	input  wire logic [2:0]            operation,
	input  wire logic [PORT_KEY_W-1:0] player_key,
	input  wire logic                  rsp_valid,
	input  wire logic                  rsp_stall,
	input  wire logic [2:0]            status,
	input  wire logic [PORT_KEY_W-1:0] result_key,
	input  wire logic                  last,
	output int                         fail_count,
	output int                         beats_due
);

	typedef struct packed {
		status_e               status;
		logic [PORT_KEY_W-1:0] key;
		logic                  last;
	} ring_beat_t;

	logic [KEY_BITS-1:0] turn_order [CAPACITY];
	int                  held;
	ring_beat_t          due_beats [$];
	int                  errors;

	function automatic ring_beat_t make_beat(status_e st, logic [KEY_BITS-1:0] k, logic lst);
		ring_beat_t b;
		b.status = st;
		b.key    = PORT_KEY_W'(k);
		b.last   = lst;
		return b;
	endfunction

	task automatic apply_request(input logic [2:0] op, input logic [PORT_KEY_W-1:0] raw_key);
		logic [KEY_BITS-1:0] k;
		logic [KEY_BITS-1:0] head;
		int                  i;
		int                  hit;
		k = KEY_BITS'(raw_key);
		if (op > OP_CLEAR)
			return;
		if (op == OP_ADD) begin
			if (held >= CAPACITY) begin
				due_beats.push_back(make_beat(ST_FULL, k, 1'b1));
			end else begin
				turn_order[held] = k;
				held++;
				due_beats.push_back(make_beat(ST_ADDED, k, 1'b1));
			end
		end else if (held == 0) begin
			due_beats.push_back(make_beat(ST_EMPTY, '0, 1'b1));
		end else begin
			case (op)
			OP_REMOVE: begin
				hit = -1;
				for (i = 0; i < held; i++)
					if (hit < 0 && turn_order[i] == k)
						hit = i;
				// a miss leaves the ring alone and gives no beat
				if (hit >= 0) begin
					for (i = hit; i < held - 1; i++)
						turn_order[i] = turn_order[i + 1];
					held--;
					due_beats.push_back(make_beat(ST_REMOVED, k, 1'b1));
				end
			end
			OP_ROTATE: begin
				head = turn_order[0];
				for (i = 0; i < held - 1; i++)
					turn_order[i] = turn_order[i + 1];
				turn_order[held - 1] = head;
				due_beats.push_back(make_beat(ST_NEXT, turn_order[0], 1'b1));
			end
			OP_LIST: begin
				for (i = 0; i < held; i++)
					due_beats.push_back(make_beat(ST_LISTED, turn_order[i], i == held - 1));
			end
			default: begin
				held = 0;
				due_beats.push_back(make_beat(ST_CLEARED, '0, 1'b1));
			end
			endcase
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		ring_beat_t want;
		if (!arst_n) begin
			held = 0;
			due_beats.delete();
			errors = 0;
			fail_count <= 0;
			beats_due <= 0;
		end else begin
			if (req_valid && !req_stall)
				apply_request(operation, player_key);
			if (rsp_valid && !rsp_stall) begin
				if (due_beats.size() == 0) begin
					errors++;
					$display("%0t: unexpected beat: expected none, got status %0d key %h last %b",
						$time, status, result_key, last);
				end else begin
					want = due_beats.pop_front();
					if (status !== want.status) begin
						errors++;
						$display("%0t: status: expected %0d, got %0d", $time, want.status, status);
					end
					if (result_key !== want.key) begin
						errors++;
						$display("%0t: result_key: expected %h, got %h", $time, want.key,
							result_key);
					end
					if (last !== want.last) begin
						errors++;
						$display("%0t: last: expected %b, got %b", $time, want.last, last);
					end
				end
			end
			fail_count <= errors;
			beats_due <= due_beats.size();
		end
	end

endmodule

`default_nettype wire

>>> sim/round_robin_key_ring_tb.sv
// round_robin_key_ring_tb: drives directed and random ring requests with random idling and
// a long response hold-off, and gives the verdict. Depends on rrk_pkg, round_robin_key_ring
// and round_robin_key_ring_checker.
`default_nettype none

module round_robin_key_ring_tb;
	import rrk_pkg::*;

	localparam int RANDOM_OPS  = 175;
	localparam int HOLD_OFF    = 80;
	localparam int SETTLE      = 2 * RRK_CAPACITY + 16;
	localparam int CYCLE_LIMIT = 200000;

	typedef enum int {
		PH_DIRECTED,
		PH_RANDOM,
		PH_QUIET,
		PH_PRESSURE
	} phase_e;

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  req_valid  = 1'b0;
	logic [2:0]            operation  = '0;
	logic [PORT_KEY_W-1:0] player_key = '0;
	logic                  rsp_stall  = 1'b0;
	logic                  req_stall;
	logic                  rsp_valid;
	logic [2:0]            status;
	logic [PORT_KEY_W-1:0] result_key;
	logic                  last;
	int                    fail_count;
	int                    beats_due;
	int                    cycles     = 0;
	phase_e                phase      = PH_DIRECTED;
	logic [PORT_KEY_W-1:0] key_pool [8];

	round_robin_key_ring dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.operation  (operation),
		.player_key (player_key),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.status     (status),
		.result_key (result_key),
		.last       (last)
	);

	round_robin_key_ring_checker ring_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.operation  (operation),
		.player_key (player_key),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.status     (status),
		.result_key (result_key),
		.last       (last),
		.fail_count (fail_count),
		.beats_due  (beats_due)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin : rsp_side
		int held_for;
		bit hold_done;
		held_for = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (phase == PH_PRESSURE && !hold_done) begin
				rsp_stall <= 1'b1;
				held_for++;
				if (held_for >= HOLD_OFF)
					hold_done = 1'b1;
			end else if (phase == PH_QUIET) begin
				rsp_stall <= 1'b0;
			end else begin
				rsp_stall <= ($urandom_range(99) < 18);
			end
		end
	end

	task automatic offer(input logic [2:0] op, input logic [PORT_KEY_W-1:0] k);
		while (phase != PH_QUIET && $urandom_range(99) < 18) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		operation <= op;
		player_key <= k;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
	endtask

	initial begin : stimulus
		int         n;
		int         i;
		int         r;
		bit         filling;
		logic [2:0] op;
		logic [PORT_KEY_W-1:0] k;
		key_pool[0] = '0;
		key_pool[1] = '1;
		key_pool[2] = 32'hAAAA_AAAA;
		key_pool[3] = 32'h5555_5555;
		for (i = 4; i < 8; i++)
			key_pool[i] = $urandom;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// empty ring
		offer(OP_LIST, '0);
		offer(OP_ROTATE, '0);
		offer(OP_REMOVE, '1);
		offer(OP_CLEAR, '0);
		// single entry rotate
		offer(OP_ADD, '0);
		offer(OP_ROTATE, $urandom);
		// fill with duplicates, then overflow
		for (i = 1; i < RRK_CAPACITY; i++)
			offer(OP_ADD, key_pool[i % 8]);
		offer(OP_ADD, $urandom);
		offer(OP_LIST, '0);
		offer(OP_REMOVE, key_pool[1]);
		offer(OP_REMOVE, 32'h0BAD_F00D);
		offer(OP_ROTATE, '0);
		offer(3'd5, '1);
		offer(OP_CLEAR, '0);

		phase <= PH_RANDOM;
		n = 0;
		filling = 1'b1;
		while (n < RANDOM_OPS) begin
			if (n == 70)
				phase <= PH_QUIET;
			else if (n == 110)
				phase <= PH_PRESSURE;
			else if (n == 150)
				phase <= PH_RANDOM;
			if (n % 24 == 0)
				filling = 1'($urandom_range(1));
			r = $urandom_range(99);
			if (r < 4)
				op = 3'($urandom_range(5, 7));
			else if (r < (filling ? 60 : 30))
				op = OP_ADD;
			else if (r < (filling ? 75 : 65))
				op = OP_REMOVE;
			else if (r < 85)
				op = OP_ROTATE;
			else if (r < 98)
				op = OP_LIST;
			else
				op = OP_CLEAR;
			k = ($urandom_range(99) < 15) ? PORT_KEY_W'($urandom) : key_pool[$urandom_range(7)];
			offer(op, k);
			if (op <= OP_CLEAR)
				n++;
		end
		req_valid <= 1'b0;

		do
			@(posedge clk);
		while (beats_due != 0);
		// a trailing remove miss may still be circulating
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0 && beats_due == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire
